// ===== design/buddy_block_allocator_macros.svh =====
// Assertion macros used by the buddy block allocator sequencer (bba_ctrl).
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define BBA_ASSERT_IMP(lbl, ante, cons, msg)
`define BBA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/bba_pkg.sv =====
// Types, constants and helper functions of the buddy block allocator.
`timescale 1ns / 1ps
package bba_pkg;
	localparam int MAX_LEVEL    = 12;
	localparam int HEADER_BYTES = 8;
	localparam int GRAN_SHIFT   = 3;
	localparam int GRAN_W       = MAX_LEVEL - GRAN_SHIFT;
	localparam int NGRAN        = 1 << GRAN_W;
	localparam int NLEV         = MAX_LEVEL + 1;
	localparam int LEV_W        = $clog2(NLEV);
	localparam int LEN_W        = GRAN_W + 1;
	localparam int ADDR_W       = 12;
	localparam int REQ_W        = 13;
	localparam int CFG_W        = 4;
	localparam int MIN_ARENA    = 4;
	localparam int ARENA_RESET  = (12 < MAX_LEVEL) ? 12 : MAX_LEVEL;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

	typedef struct packed {
		logic [GRAN_W-1:0] nxt;
		logic [GRAN_W-1:0] prv;
		logic              has_next;
		logic              has_prev;
		logic [LEV_W-1:0]  level;
		logic              free;
		logic              head;
	} gran_t;

	typedef struct packed {
		logic              cmd;
		logic [REQ_W-1:0]  req;
		logic [ADDR_W-1:0] addr;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		status_t           status;
	} result_t;

	// Number of bits of request plus header less one, never below one granule.
	function automatic logic [LEV_W-1:0] need_level(input logic [REQ_W-1:0] req);
		logic [REQ_W:0]   x;
		logic [LEV_W-1:0] n;
		x = {1'b0, req} + (REQ_W+1)'(HEADER_BYTES - 1);
		n = LEV_W'(GRAN_SHIFT);
		for (int i = 0; i <= REQ_W; i++) begin
			if (x[i] && (i + 1) > GRAN_SHIFT) n = LEV_W'(i + 1);
		end
		return n;
	endfunction
endpackage

// ===== design/bba_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== design/bba_ctrl.sv =====
// Sequencer of the buddy allocator: level tables, granule store and split/merge steps.
`timescale 1ns / 1ps
`include "buddy_block_allocator_macros.svh"
module bba_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bba_pkg::LEV_W-1:0]   arena,
	input  logic                        restart,
	input  logic [bba_pkg::LEV_W-1:0]   restart_lev,
	input  logic                        in_valid,
	input  bba_pkg::item_t              item,
	output logic                        in_ready,
	output logic                        res_valid,
	input  logic                        res_take,
	output bba_pkg::result_t            res
);
	typedef enum logic [4:0] {
		S_CLR, S_INIT, S_IDLE, S_A_CHK, S_A_SPLIT, S_A_FIN,
		S_F_CHK, S_F_LOOP, S_F_BCHK, S_F_MERGE, S_F_GH, S_F_FIN,
		S_U0, S_U_P, S_U_N0, S_U_N, S_U_G, S_P0, S_P1, S_DONE
	} state_t;

	localparam int GW = bba_pkg::GRAN_W;
	localparam int LW = bba_pkg::LEV_W;
	localparam int NL = bba_pkg::NLEV;

	state_t               state_q, ret_q;
	logic [GW-1:0]        clr_q, g_q, b_q, ul_g_q, pu_g_q, pu_h_q;
	logic [LW-1:0]        need_q, lev_q, pu_lev_q;
	logic                 ul_clr_head_q;
	bba_pkg::gran_t       ul_rec_q;
	bba_pkg::result_t     res_q;
	logic [GW-1:0]        list_head_q [NL];
	logic [bba_pkg::LEN_W-1:0] len_q [NL];
	logic [NL-1:0]        nonempty_q;

	logic                 ram_we, ram_re;
	logic [GW-1:0]        ram_waddr, ram_raddr;
	bba_pkg::gran_t       ram_wdata, rd;
	logic [$bits(bba_pkg::gran_t)-1:0] ram_rdata;

	logic [bba_pkg::ADDR_W-1:0] off;
	logic                 bad_free, found;
	logic [LW-1:0]        found_lev, split_lev;
	logic [GW-1:0]        gidx, bud, half;

	bba_ram #(.WIDTH($bits(bba_pkg::gran_t)), .DEPTH(bba_pkg::NGRAN)) u_gran_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd = bba_pkg::gran_t'(ram_rdata);

	always_comb begin
		off = item.addr - bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES);
		bad_free = (item.addr < bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES))
			|| ((bba_pkg::ADDR_W+1)'(off) >= ((bba_pkg::ADDR_W+1)'(1) << arena))
			|| (off[bba_pkg::GRAN_SHIFT-1:0] != '0);
		gidx = off[bba_pkg::GRAN_SHIFT +: GW];
		bud = g_q ^ (GW'(1) << (lev_q - LW'(bba_pkg::GRAN_SHIFT)));
		split_lev = lev_q - LW'(1);
		half = g_q + (GW'(1) << (split_lev - LW'(bba_pkg::GRAN_SHIFT)));
		found = 1'b0;
		found_lev = '0;
		for (int i = NL - 1; i >= 0; i--) begin
			if (nonempty_q[i] && LW'(i) >= need_q && LW'(i) <= arena) begin
				found = 1'b1;
				found_lev = LW'(i);
			end
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_CLR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
			end
			S_INIT: begin
				ram_we = 1'b1;
				ram_wdata.level = arena;
				ram_wdata.free = 1'b1;
				ram_wdata.head = 1'b1;
			end
			S_IDLE: begin
				ram_re = in_valid && item.cmd == bba_pkg::CMD_FREE && !bad_free;
				ram_raddr = gidx;
			end
			S_A_CHK: begin
				ram_re = need_q <= arena && found;
				ram_raddr = list_head_q[found_lev];
			end
			S_A_FIN: begin
				ram_we = 1'b1;
				ram_waddr = g_q;
				ram_wdata.level = need_q;
				ram_wdata.head = 1'b1;
			end
			S_F_LOOP: begin
				ram_re = lev_q < arena;
				ram_raddr = bud;
			end
			S_F_MERGE: begin
				ram_re = b_q < g_q;
				ram_raddr = g_q;
			end
			S_F_GH: begin
				ram_we = 1'b1;
				ram_waddr = g_q;
				ram_wdata = rd;
				ram_wdata.head = 1'b0;
			end
			S_U0: begin
				ram_re = rd.has_prev;
				ram_raddr = rd.prv;
			end
			S_U_P: begin
				ram_we = 1'b1;
				ram_waddr = ul_rec_q.prv;
				ram_wdata = rd;
				ram_wdata.nxt = ul_rec_q.nxt;
				ram_wdata.has_next = ul_rec_q.has_next;
			end
			S_U_N0: begin
				ram_re = ul_rec_q.has_next;
				ram_raddr = ul_rec_q.nxt;
			end
			S_U_N: begin
				ram_we = 1'b1;
				ram_waddr = ul_rec_q.nxt;
				ram_wdata = rd;
				ram_wdata.prv = ul_rec_q.prv;
				ram_wdata.has_prev = ul_rec_q.has_prev;
			end
			S_U_G: begin
				ram_we = 1'b1;
				ram_waddr = ul_g_q;
				ram_wdata = ul_rec_q;
				ram_wdata.has_next = 1'b0;
				ram_wdata.has_prev = 1'b0;
				ram_wdata.free = 1'b0;
				ram_wdata.head = ul_rec_q.head && !ul_clr_head_q;
			end
			S_P0: begin
				ram_we = 1'b1;
				ram_waddr = pu_g_q;
				ram_wdata.nxt = list_head_q[pu_lev_q];
				ram_wdata.has_next = nonempty_q[pu_lev_q];
				ram_wdata.level = pu_lev_q;
				ram_wdata.free = 1'b1;
				ram_wdata.head = 1'b1;
				ram_re = nonempty_q[pu_lev_q];
				ram_raddr = list_head_q[pu_lev_q];
			end
			S_P1: begin
				ram_we = 1'b1;
				ram_waddr = pu_h_q;
				ram_wdata = rd;
				ram_wdata.prv = pu_g_q;
				ram_wdata.has_prev = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ret_q <= S_IDLE;
			clr_q <= '0;
			g_q <= '0;
			b_q <= '0;
			ul_g_q <= '0;
			pu_g_q <= '0;
			pu_h_q <= '0;
			need_q <= '0;
			lev_q <= '0;
			pu_lev_q <= '0;
			ul_clr_head_q <= 1'b0;
			ul_rec_q <= '0;
			res_q <= '0;
			nonempty_q <= NL'(1) << bba_pkg::ARENA_RESET;
			for (int i = 0; i < NL; i++) begin
				list_head_q[i] <= '0;
				len_q[i] <= (i == bba_pkg::ARENA_RESET) ? bba_pkg::LEN_W'(1) : '0;
			end
		end else if (restart) begin
			state_q <= S_CLR;
			clr_q <= '0;
			nonempty_q <= NL'(1) << restart_lev;
			for (int i = 0; i < NL; i++) begin
				list_head_q[i] <= '0;
				len_q[i] <= (LW'(i) == restart_lev) ? bba_pkg::LEN_W'(1) : '0;
			end
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + GW'(1);
					if (&clr_q) state_q <= S_INIT;
				end
				S_INIT: state_q <= S_IDLE;
				S_IDLE: begin
					if (in_valid) begin
						if (item.cmd == bba_pkg::CMD_ALLOC) begin
							need_q <= bba_pkg::need_level(item.req);
							state_q <= S_A_CHK;
						end else if (bad_free) begin
							res_q <= '{addr: '0, status: bba_pkg::ST_BAD_FREE};
							state_q <= S_DONE;
						end else begin
							g_q <= gidx;
							state_q <= S_F_CHK;
						end
					end
				end
				S_A_CHK: begin
					if (need_q > arena || !found) begin
						res_q <= '{addr: '0, status: bba_pkg::ST_NO_SPACE};
						state_q <= S_DONE;
					end else begin
						lev_q <= found_lev;
						g_q <= list_head_q[found_lev];
						ul_g_q <= list_head_q[found_lev];
						ul_clr_head_q <= 1'b0;
						ret_q <= S_A_SPLIT;
						state_q <= S_U0;
					end
				end
				S_A_SPLIT: begin
					if (lev_q > need_q) begin
						lev_q <= split_lev;
						pu_g_q <= half;
						pu_lev_q <= split_lev;
						ret_q <= S_A_SPLIT;
						state_q <= S_P0;
					end else begin
						state_q <= S_A_FIN;
					end
				end
				S_A_FIN: begin
					res_q <= '{addr: {g_q, bba_pkg::GRAN_SHIFT'(0)}
						+ bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES),
						status: bba_pkg::ST_OK};
					state_q <= S_DONE;
				end
				S_F_CHK: begin
					if (!rd.head || rd.free) begin
						res_q <= '{addr: '0, status: bba_pkg::ST_BAD_FREE};
						state_q <= S_DONE;
					end else begin
						lev_q <= rd.level;
						state_q <= S_F_LOOP;
					end
				end
				S_F_LOOP: begin
					if (lev_q < arena) begin
						b_q <= bud;
						state_q <= S_F_BCHK;
					end else begin
						pu_g_q <= g_q;
						pu_lev_q <= lev_q;
						ret_q <= S_F_FIN;
						state_q <= S_P0;
					end
				end
				S_F_BCHK: begin
					if (!rd.head || !rd.free || rd.level != lev_q) begin
						pu_g_q <= g_q;
						pu_lev_q <= lev_q;
						ret_q <= S_F_FIN;
						state_q <= S_P0;
					end else begin
						ul_g_q <= b_q;
						ul_clr_head_q <= b_q > g_q;
						ret_q <= S_F_MERGE;
						state_q <= S_U0;
					end
				end
				S_F_MERGE: begin
					if (b_q > g_q) begin
						lev_q <= lev_q + LW'(1);
						state_q <= S_F_LOOP;
					end else begin
						state_q <= S_F_GH;
					end
				end
				S_F_GH: begin
					g_q <= b_q;
					lev_q <= lev_q + LW'(1);
					state_q <= S_F_LOOP;
				end
				S_F_FIN: begin
					res_q <= '{addr: '0, status: bba_pkg::ST_OK};
					state_q <= S_DONE;
				end
				S_U0: begin
					ul_rec_q <= rd;
					if (rd.has_prev) begin
						state_q <= S_U_P;
					end else begin
						if (rd.has_next) list_head_q[rd.level] <= rd.nxt;
						state_q <= S_U_N0;
					end
				end
				S_U_P: state_q <= S_U_N0;
				S_U_N0: state_q <= ul_rec_q.has_next ? S_U_N : S_U_G;
				S_U_N: state_q <= S_U_G;
				S_U_G: begin
					if (len_q[ul_rec_q.level] != '0)
						len_q[ul_rec_q.level] <= len_q[ul_rec_q.level] - bba_pkg::LEN_W'(1);
					if (len_q[ul_rec_q.level] <= bba_pkg::LEN_W'(1))
						nonempty_q[ul_rec_q.level] <= 1'b0;
					state_q <= ret_q;
				end
				S_P0: begin
					list_head_q[pu_lev_q] <= pu_g_q;
					len_q[pu_lev_q] <= len_q[pu_lev_q] + bba_pkg::LEN_W'(1);
					nonempty_q[pu_lev_q] <= 1'b1;
					pu_h_q <= list_head_q[pu_lev_q];
					state_q <= nonempty_q[pu_lev_q] ? S_P1 : ret_q;
				end
				S_P1: state_q <= ret_q;
				S_DONE: begin
					if (res_take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res = res_q;

	`BBA_ASSERT_IMP(a_ram_ports, ram_re && ram_we, ram_raddr != ram_waddr, "read and write hit one granule")
	`BBA_ASSERT_NXT(a_done_hold, state_q == S_DONE && !res_take && !restart, state_q == S_DONE, "result dropped")
	`BBA_ASSERT_IMP(a_level_range, state_q == S_IDLE, ((nonempty_q >> arena) <= NL'(1)) && (nonempty_q[bba_pkg::GRAN_SHIFT-1:0] == '0), "free level outside arena")
endmodule

// ===== design/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: configuration, request and result channels.
//
// Requests enter on in_valid/in_stall with cmd, request_bytes and release_address.
// An allocate answers with granted_address (block offset plus the 8-byte header)
// and status; a free answers with status only. Results leave on out_valid/out_stall.
// One request is worked on at a time by a sequencer around a granule store with one
// read and one write port; in_stall is high while it is busy. A refused request is
// answered straight from its check, with no split or merge. An allocate splits its
// block over up to nine levels, and a free merges over up to nine levels, where the
// unlink of the buddy is most of the work of each merge.
// A finished result waits in the output register; the next request is taken while
// it waits, and the sequencer holds its next result until the register empties.
// After reset, and after every write to cfg_data (arena level, saturated to 4..12),
// the granule store is cleared with in_stall high; the arena then holds one free
// block. Configuration must be written only while the block is idle.
`timescale 1ns / 1ps
module buddy_block_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bba_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [bba_pkg::REQ_W-1:0]     request_bytes,
	input  logic [bba_pkg::ADDR_W-1:0]    release_address,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bba_pkg::ADDR_W-1:0]    granted_address,
	output logic [1:0]                    status
);
	logic [bba_pkg::LEV_W-1:0] arena_q, cfg_lev;
	logic                      out_valid_q, restart, in_ready, res_valid, res_take;
	bba_pkg::result_t          out_q, res;
	bba_pkg::item_t            item;

	always_comb begin
		if (bba_pkg::LEV_W'(cfg_data) < bba_pkg::LEV_W'(bba_pkg::MIN_ARENA))
			cfg_lev = bba_pkg::LEV_W'(bba_pkg::MIN_ARENA);
		else if (bba_pkg::LEV_W'(cfg_data) > bba_pkg::LEV_W'(bba_pkg::MAX_LEVEL))
			cfg_lev = bba_pkg::LEV_W'(bba_pkg::MAX_LEVEL);
		else
			cfg_lev = bba_pkg::LEV_W'(cfg_data);
	end

	assign cfg_ready = 1'b1;
	assign restart = cfg_valid && cfg_ready;
	assign item = '{cmd: cmd, req: request_bytes, addr: release_address};
	assign in_stall = !in_ready;
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	bba_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.arena       (arena_q),
		.restart     (restart),
		.restart_lev (cfg_lev),
		.in_valid    (in_valid),
		.item        (item),
		.in_ready    (in_ready),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q <= bba_pkg::LEV_W'(bba_pkg::ARENA_RESET);
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (restart) arena_q <= cfg_lev;
			if (res_take) begin
				out_valid_q <= 1'b1;
				out_q <= res;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign granted_address = out_q.addr;
	assign status = out_q.status;
endmodule
